>>> rtl/core/hrhc_pkg.sv
// Shared types, constants and helper functions for the HTTP request header checker.
// Used by the top level and by its port checker; depends on nothing else.
package hrhc_pkg;

	// Width of the header and body byte counters (they saturate at all ones).
	localparam int COUNT_WIDTH = 17;
	// Content length is held in 17 bits so that 65536 can stand for "too large".
	localparam int LEN_W       = 17;
	localparam int LIMIT_W     = 16;
	localparam int POS_W       = 5;

	// Configuration register indexes.
	localparam logic CFG_HEADER_LIMIT = 1'b0;
	localparam logic CFG_BODY_LIMIT   = 1'b1;

	localparam logic [LIMIT_W-1:0] HEADER_LIMIT_RST = 16'd8192;
	localparam logic [LIMIT_W-1:0] BODY_LIMIT_RST   = 16'd4096;

	// Fixed request line, including its CR LF.
	localparam int             REQ_LEN  = 31;
	localparam logic [8*REQ_LEN-1:0] REQ_LINE = "POST /api/v1/request HTTP/1.1\r\n";

	// Header names that are looked for, stored in lower case.
	localparam logic [1:0] NAME_CL = 2'd0;
	localparam logic [1:0] NAME_TE = 2'd1;
	localparam logic [1:0] NAME_EX = 2'd2;
	localparam int NUM_NAMES = 3;

	localparam int CL_LEN = 14;
	localparam int TE_LEN = 17;
	localparam int EX_LEN = 6;
	localparam logic [8*CL_LEN-1:0] CL_STR = "content-length";
	localparam logic [8*TE_LEN-1:0] TE_STR = "transfer-encoding";
	localparam logic [8*EX_LEN-1:0] EX_STR = "expect";

	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_COLON = 8'd58;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;

	typedef enum logic [1:0] {
		ST_INCOMPLETE = 2'd0,
		ST_READY      = 2'd1,
		ST_INVALID    = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_req;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic       body_valid;
		logic [7:0] body_byte;
	} verdict_t;

	function automatic logic [7:0] req_char(input logic [POS_W-1:0] pos);
		logic [7:0] c;
		c = 8'd0;
		if (int'(pos) < REQ_LEN) begin
			c = REQ_LINE[8*(REQ_LEN-1-int'(pos)) +: 8];
		end
		return c;
	endfunction

	function automatic logic [POS_W-1:0] name_len(input logic [1:0] idx);
		logic [POS_W-1:0] n;
		unique case (idx)
			NAME_CL: n = POS_W'(CL_LEN);
			NAME_TE: n = POS_W'(TE_LEN);
			NAME_EX: n = POS_W'(EX_LEN);
			default: n = '0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] name_char(input logic [1:0] idx,
			input logic [POS_W-1:0] pos);
		logic [7:0] c;
		c = 8'd0;
		unique case (idx)
			NAME_CL: begin
				if (int'(pos) < CL_LEN) c = CL_STR[8*(CL_LEN-1-int'(pos)) +: 8];
			end
			NAME_TE: begin
				if (int'(pos) < TE_LEN) c = TE_STR[8*(TE_LEN-1-int'(pos)) +: 8];
			end
			NAME_EX: begin
				if (int'(pos) < EX_LEN) c = EX_STR[8*(EX_LEN-1-int'(pos)) +: 8];
			end
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
	endfunction

endpackage

>>> rtl/core/http_request_header_checker_unit.sv
// Top level of the HTTP request header checker: input register, per-byte parse logic,
// result register and configuration registers. Depends on hrhc_pkg.
//
// A request carries one byte of an HTTP/1.1 request and its start flag; every request
// yields exactly one verdict (incomplete, ready or invalid) and, for body bytes, the byte
// itself. The block sustains one request per clock cycle while the output side does not
// stall. A request is captured in the input register, the parse logic works on it there
// and the verdict lands in the result register, which raises verdict_valid; the verdict
// is taken at an edge where verdict_stall is low. The parse state update (a few comparisons,
// one multiply-by-ten by shifts and adds, and the counters) is what sits between those two
// registers. While a verdict waits in the result register the input register still takes
// one more request; item_stall rises only when both are full and verdict_stall is high.
// The request line must read "POST /api/v1/request HTTP/1.1", header names are matched
// without regard to case, and header errors are held back until the blank line arrives
// or the header byte limit is passed. Limits are written through cfg_we/cfg_index/cfg_data
// while no request is in flight, a rule for the user that the block does not enforce;
// they take effect for the next request byte.

module http_request_header_checker_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  hrhc_pkg::item_t              item,
	output logic                         verdict_valid,
	input  logic                         verdict_stall,
	output hrhc_pkg::verdict_t           verdict,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [hrhc_pkg::LIMIT_W-1:0] cfg_data
);
	import hrhc_pkg::*;

	// Parse phase of the current request.
	typedef enum logic [6:0] {
		PH_REQ      = 7'b0000001,
		PH_REQ_SKIP = 7'b0000010,
		PH_NAME     = 7'b0000100,
		PH_VALUE    = 7'b0001000,
		PH_BODY     = 7'b0010000,
		PH_READY    = 7'b0100000,
		PH_BAD      = 7'b1000000
	} phase_t;

	// Progress through a content-length value.
	typedef enum logic [3:0] {
		VP_LEAD   = 4'b0001,
		VP_DIGITS = 4'b0010,
		VP_TRAIL  = 4'b0100,
		VP_BAD    = 4'b1000
	} vphase_t;

	localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
	localparam logic [POS_W-1:0]       POS_MAX  = {POS_W{1'b1}};
	localparam logic [LEN_W+2:0]       LEN_TOP  = (LEN_W+3)'(65535);
	localparam logic [LEN_W-1:0]       LEN_SAT  = LEN_W'(65536);

	// Configuration registers.
	logic [LIMIT_W-1:0] header_limit_q;
	logic [LIMIT_W-1:0] body_limit_q;

	// Input register and result register.
	item_t    item_s1;
	logic     valid_s1;
	verdict_t verdict_q;
	logic     verdict_valid_q;

	// Parse state.
	phase_t                 phase_q;
	logic [POS_W-1:0]       mpos_q;
	logic [NUM_NAMES-1:0]   cand_q;
	vphase_t                vphase_q;
	logic [COUNT_WIDTH-1:0] byte_count_q;
	logic [LEN_W-1:0]       length_value_q;
	logic                   length_seen_q;
	logic [COUNT_WIDTH-1:0] body_count_q;
	logic                   pending_cr_q;
	logic                   error_q;

	// Next-state values.
	phase_t                 phase_d;
	logic [POS_W-1:0]       mpos_d;
	logic [NUM_NAMES-1:0]   cand_d;
	vphase_t                vphase_d;
	logic [COUNT_WIDTH-1:0] byte_count_d;
	logic [LEN_W-1:0]       length_value_d;
	logic                   length_seen_d;
	logic [COUNT_WIDTH-1:0] body_count_d;
	logic                   pending_cr_d;
	logic                   error_d;
	verdict_t               verdict_d;

	logic advance;

	// The parse stage moves on whenever the result register is empty or being drained.
	assign advance       = valid_s1 && (!verdict_valid_q || !verdict_stall);
	assign item_stall    = valid_s1 && verdict_valid_q && verdict_stall;
	assign verdict_valid = verdict_valid_q;
	assign verdict       = verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_limit_q <= HEADER_LIMIT_RST;
			body_limit_q   <= BODY_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEADER_LIMIT: header_limit_q <= cfg_data;
				CFG_BODY_LIMIT:   body_limit_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Per-byte parse logic. A start flag first brings the state back to its cleared values,
	// then the byte is applied to that state.
	always_comb begin
		logic [7:0]    b;
		logic          crlf;
		logic          hdr_done;
		logic [NUM_NAMES-1:0] hit;
		logic [LEN_W+2:0] len_x10;

		b        = item_s1.data_byte;
		crlf     = 1'b0;
		hdr_done = 1'b0;
		hit      = '0;
		len_x10  = '0;

		if (item_s1.start_req) begin
			phase_d        = PH_REQ;
			mpos_d         = '0;
			cand_d         = '1;
			vphase_d       = VP_LEAD;
			byte_count_d   = '0;
			length_value_d = '0;
			length_seen_d  = 1'b0;
			body_count_d   = '0;
			pending_cr_d   = 1'b0;
			error_d        = 1'b0;
		end else begin
			phase_d        = phase_q;
			mpos_d         = mpos_q;
			cand_d         = cand_q;
			vphase_d       = vphase_q;
			byte_count_d   = byte_count_q;
			length_value_d = length_value_q;
			length_seen_d  = length_seen_q;
			body_count_d   = body_count_q;
			pending_cr_d   = pending_cr_q;
			error_d        = error_q;
		end

		verdict_d.status     = ST_INCOMPLETE;
		verdict_d.body_valid = 1'b0;
		verdict_d.body_byte  = 8'd0;

		unique case (phase_d)
			PH_BAD: begin
				verdict_d.status = ST_INVALID;
			end
			PH_READY: begin
				// Any byte after the whole body is surplus.
				phase_d          = PH_BAD;
				verdict_d.status = ST_INVALID;
			end
			PH_BODY: begin
				verdict_d.body_valid = 1'b1;
				verdict_d.body_byte  = b;
				if (body_count_d != CNT_MAX) body_count_d = body_count_d + 1'b1;
				if (CMP_W'(body_count_d) >= CMP_W'(length_value_d)) begin
					phase_d          = PH_READY;
					verdict_d.status = ST_READY;
				end
			end
			default: begin
				if (byte_count_d != CNT_MAX) byte_count_d = byte_count_d + 1'b1;
				if (CMP_W'(byte_count_d) > CMP_W'(header_limit_q)) begin
					phase_d          = PH_BAD;
					verdict_d.status = ST_INVALID;
				end else begin
					crlf         = pending_cr_d && (b == CHAR_LF);
					pending_cr_d = (b == CHAR_CR);

					unique case (phase_d)
						PH_REQ: begin
							if (int'(mpos_d) < REQ_LEN && b == req_char(mpos_d)) begin
								mpos_d = mpos_d + 1'b1;
								if (int'(mpos_d) >= REQ_LEN) begin
									phase_d  = PH_NAME;
									mpos_d   = '0;
									cand_d   = '1;
									vphase_d = VP_LEAD;
								end
							end else begin
								error_d = 1'b1;
								phase_d = PH_REQ_SKIP;
							end
						end
						PH_REQ_SKIP: begin
							if (crlf) begin
								phase_d  = PH_NAME;
								mpos_d   = '0;
								cand_d   = '1;
								vphase_d = VP_LEAD;
							end
						end
						PH_NAME: begin
							if (crlf) begin
								// Only the CR was counted: this is the blank line.
								if (mpos_d == POS_W'(1)) begin
									hdr_done = 1'b1;
								end else begin
									error_d  = 1'b1;
									mpos_d   = '0;
									cand_d   = '1;
									vphase_d = VP_LEAD;
								end
							end else if (b == CHAR_COLON) begin
								if (mpos_d == '0) error_d = 1'b1;
								for (int i = 0; i < NUM_NAMES; i++) begin
									hit[i] = cand_d[i] && (name_len(2'(i)) == mpos_d);
								end
								if (hit[NAME_TE] || hit[NAME_EX]) error_d = 1'b1;
								if (hit[NAME_CL]) begin
									if (length_seen_d) error_d = 1'b1;
									length_seen_d  = 1'b1;
									length_value_d = '0;
								end
								cand_d   = hit;
								vphase_d = VP_LEAD;
								phase_d  = PH_VALUE;
							end else begin
								for (int i = 0; i < NUM_NAMES; i++) begin
									if (cand_d[i] && (mpos_d >= name_len(2'(i)) ||
											to_lower(b) != name_char(2'(i), mpos_d))) begin
										cand_d[i] = 1'b0;
									end
								end
								if (mpos_d != POS_MAX) mpos_d = mpos_d + 1'b1;
							end
						end
						PH_VALUE: begin
							if (crlf) begin
								if (cand_d[NAME_CL] &&
										(vphase_d == VP_LEAD || vphase_d == VP_BAD)) begin
									error_d = 1'b1;
								end
								phase_d  = PH_NAME;
								mpos_d   = '0;
								cand_d   = '1;
								vphase_d = VP_LEAD;
							end else if (cand_d[NAME_CL]) begin
								if (is_ws(b)) begin
									if (vphase_d == VP_DIGITS) vphase_d = VP_TRAIL;
								end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
									if (vphase_d == VP_LEAD || vphase_d == VP_DIGITS) begin
										// Times ten as eight plus two; large values clamp.
										len_x10 = {length_value_d, 3'b000} +
											{2'b00, length_value_d, 1'b0} +
											(LEN_W+3)'(b - CHAR_ZERO);
										if (len_x10 > LEN_TOP) begin
											length_value_d = LEN_SAT;
										end else begin
											length_value_d = len_x10[LEN_W-1:0];
										end
										vphase_d = VP_DIGITS;
									end else begin
										vphase_d = VP_BAD;
									end
								end else begin
									vphase_d = VP_BAD;
								end
							end
						end
						default: ;
					endcase

					if (hdr_done) begin
						if (error_d || !length_seen_d || length_value_d == '0 ||
								length_value_d > LEN_W'(body_limit_q)) begin
							phase_d          = PH_BAD;
							verdict_d.status = ST_INVALID;
						end else begin
							phase_d      = PH_BODY;
							body_count_d = '0;
						end
					end
				end
			end
		endcase
	end

	// Control: input and result valid flags and the parse state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			verdict_valid_q <= 1'b0;
			phase_q         <= PH_REQ;
			mpos_q          <= '0;
			cand_q          <= '1;
			vphase_q        <= VP_LEAD;
			byte_count_q    <= '0;
			length_value_q  <= '0;
			length_seen_q   <= 1'b0;
			body_count_q    <= '0;
			pending_cr_q    <= 1'b0;
			error_q         <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				verdict_valid_q <= 1'b1;
				phase_q         <= phase_d;
				mpos_q          <= mpos_d;
				cand_q          <= cand_d;
				vphase_q        <= vphase_d;
				byte_count_q    <= byte_count_d;
				length_value_q  <= length_value_d;
				length_seen_q   <= length_seen_d;
				body_count_q    <= body_count_d;
				pending_cr_q    <= pending_cr_d;
				error_q         <= error_d;
			end else if (!verdict_stall) begin
				verdict_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (advance) begin
			verdict_q <= verdict_d;
		end
	end

endmodule

>>> rtl/core/hrhc_checker.sv
// Port-level checker for the HTTP request header checker, bound to its top level.
// Depends on hrhc_pkg and http_request_header_checker_unit.
module hrhc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic               verdict_valid,
	input  logic               verdict_stall,
	input  hrhc_pkg::verdict_t verdict
);
	import hrhc_pkg::*;

	// A verdict held under stall keeps its value.
	a_verdict_hold: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && verdict_stall |=> verdict_valid && $stable(verdict))
		else $error("verdict changed while stalled");

	// The input side only stalls when a verdict is waiting and held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> verdict_valid && verdict_stall)
		else $error("input stalled without a held verdict");

	// An accepted request reaches the output through the input and result registers if the output drains.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall ##1 !(verdict_valid && verdict_stall) |=> verdict_valid)
		else $error("verdict missing after accepted request");

	// Body bytes are never flagged invalid, and no byte is passed without body_valid.
	a_body_status: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (verdict.body_valid ? verdict.status != ST_INVALID
			: verdict.body_byte == 8'd0))
		else $error("inconsistent body fields in verdict");

endmodule

bind http_request_header_checker_unit hrhc_checker u_hrhc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item_valid),
	.item_stall    (item_stall),
	.verdict_valid (verdict_valid),
	.verdict_stall (verdict_stall),
	.verdict       (verdict)
);
